// File: src/console_output_cursor_tracker_macros.svh
// assertion helpers used by the checker of the console tracker
`ifndef CONSOLE_OUTPUT_CURSOR_TRACKER_MACROS_SVH
`define CONSOLE_OUTPUT_CURSOR_TRACKER_MACROS_SVH

// same-cycle implication, disabled during reset
`define COCT_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define COCT_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/coct_pkg.sv
package coct_pkg;

  // input opcodes
  localparam logic [1:0] OP_TEXT  = 2'd0;
  localparam logic [1:0] OP_RAW   = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // bytes with a meaning to the tracker
  localparam logic [7:0] CHR_BS    = 8'h08;
  localparam logic [7:0] CHR_TAB   = 8'h09;
  localparam logic [7:0] CHR_LF    = 8'h0A;
  localparam logic [7:0] CHR_CR    = 8'h0D;
  localparam logic [7:0] CHR_SPACE = 8'h20;

  localparam int DEFAULT_COLS = 80;
  localparam int DEFAULT_ROWS = 24;
  localparam int TAB_STEP     = 4;

  // erase display then home, seven bytes
  localparam int CLEAR_LEN = 7;

  localparam int REG_COLS = 0;
  localparam int REG_ROWS = 1;

  typedef enum logic [1:0] {
    RUN_SINGLE,
    RUN_CRLF,
    RUN_CLEAR
  } run_kind_t;

  function automatic logic [7:0] clear_seq_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'h1B;
      3'd1:    b = 8'h5B;
      3'd2:    b = 8'h32;
      3'd3:    b = 8'h4A;
      3'd4:    b = 8'h1B;
      3'd5:    b = 8'h5B;
      3'd6:    b = 8'h48;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// File: src/coct_if.sv
interface coct_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] in_byte;
  logic       text_start;

  modport source (output valid, output opcode, output in_byte, output text_start,
                  input ready);
  modport sink (input valid, input opcode, input in_byte, input text_start,
                output ready);
endinterface

interface coct_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;
  logic [7:0] row_now;
  logic [7:0] col_now;

  modport source (output valid, output out_byte, output last_of_run, output row_now,
                  output col_now, input ready);
  modport sink (input valid, input out_byte, input last_of_run, input row_now,
                input col_now, output ready);
endinterface

// File: src/console_output_cursor_tracker.sv
// the first byte of an item shows on out_ch in the cycle after the item is taken
// throughput: one item per cycle for single-byte items while the sink is ready; a
//   line feed expanded to CR LF or a clear holds the input until its last byte goes,
//   set by the single run register that steps through the bytes of one item
// reset (rst_n low, synchronous): cursor at row 0 column 0, no CR held, no run
//   pending, screen size back to 80 by 24
module console_output_cursor_tracker #(
  parameter int DIM_BITS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  coct_in_if.sink           in_ch,
  coct_out_if.source        out_ch,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [2:0]        cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  // working width for cursor math: holds a dimension plus one and the defaults
  localparam int CW = (DIM_BITS + 1 > 8) ? DIM_BITS + 1 : 8;

  localparam logic [DIM_BITS-1:0] COLS_RST = DIM_BITS'(coct_pkg::DEFAULT_COLS);
  localparam logic [DIM_BITS-1:0] ROWS_RST = DIM_BITS'(coct_pkg::DEFAULT_ROWS);

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [DIM_BITS-1:0] cols_r;
  logic [DIM_BITS-1:0] rows_r;
  logic                cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  // only address bit 2 selects the register, low bits ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= COLS_RST;
      rows_r <= ROWS_RST;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == 1'(coct_pkg::REG_ROWS)) begin
        rows_r <= cfg_pwdata[DIM_BITS-1:0];
      end else begin
        cols_r <= cfg_pwdata[DIM_BITS-1:0];
      end
    end
  end

  always_comb begin
    if (cfg_paddr[2] == 1'(coct_pkg::REG_ROWS)) begin
      cfg_prdata = 32'(rows_r);
    end else begin
      cfg_prdata = 32'(cols_r);
    end
  end

  // ---------------------------------------------------------------------------
  // cursor state, updated when an item is taken
  // ---------------------------------------------------------------------------
  logic [DIM_BITS-1:0] row_r, row_nxt;
  logic [DIM_BITS-1:0] col_r, col_nxt;
  logic                prev_cr_r, prev_cr_nxt;

  // run register: bytes of the current item waiting for the sink
  logic                  run_v_r, run_v_nxt;
  coct_pkg::run_kind_t   run_kind_r, run_kind_nxt;
  logic [7:0]            run_byte_r, run_byte_nxt;
  logic [7:0]            run_row_r, run_row_nxt;
  logic [7:0]            run_col_r, run_col_nxt;
  logic [2:0]            idx_r, idx_nxt;

  logic in_fire;
  logic out_fire;
  logic run_last;

  // the run ends when its last byte goes; a new item may load in that cycle
  assign in_ch.ready = !run_v_r || (out_ch.ready && run_last);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_fire    = run_v_r && out_ch.ready;

  // effective screen size, zero means default
  logic [CW-1:0] eff_cols;
  logic [CW-1:0] eff_rows;

  assign eff_cols = (cols_r == '0) ? CW'(coct_pkg::DEFAULT_COLS) : CW'(cols_r);
  assign eff_rows = (rows_r == '0) ? CW'(coct_pkg::DEFAULT_ROWS) : CW'(rows_r);

  // tracking of a text byte
  logic [CW-1:0] col_ext, row_ext;
  logic [CW-1:0] col_step;
  logic [CW-1:0] col_trk, row_trk;
  logic          down_lf;
  logic          wrap;
  logic [CW-1:0] row_plus;

  always_comb begin
    col_ext  = CW'(col_r);
    row_ext  = CW'(row_r);
    row_plus = row_ext + CW'(1);
    down_lf  = 1'b0;

    if (in_ch.in_byte == coct_pkg::CHR_CR) begin
      col_step = '0;
    end else if (in_ch.in_byte == coct_pkg::CHR_LF) begin
      col_step = '0;
      down_lf  = 1'b1;
    end else if (in_ch.in_byte == coct_pkg::CHR_BS) begin
      col_step = (col_ext != '0) ? col_ext - CW'(1) : col_ext;
    end else if (in_ch.in_byte == coct_pkg::CHR_TAB) begin
      // next multiple of four
      col_step = (col_ext + CW'(coct_pkg::TAB_STEP)) & ~CW'(coct_pkg::TAB_STEP - 1);
    end else if (in_ch.in_byte >= coct_pkg::CHR_SPACE) begin
      col_step = col_ext + CW'(1);
    end else begin
      col_step = col_ext;
    end

    // line feed never wraps (column is zero), so at most one step down
    wrap = (col_step >= eff_cols);
    if (wrap) begin
      col_trk = '0;
    end else begin
      col_trk = col_step;
    end

    // row saturates at the last row
    if ((down_lf || wrap) && (row_plus < eff_rows)) begin
      row_trk = row_plus;
    end else begin
      row_trk = row_ext;
    end
  end

  // next state and run load on an accepted item
  logic [CW-1:0] row_out_ext, col_out_ext;

  always_comb begin
    row_nxt      = row_r;
    col_nxt      = col_r;
    prev_cr_nxt  = prev_cr_r;
    run_v_nxt    = run_v_r;
    run_kind_nxt = run_kind_r;
    run_byte_nxt = run_byte_r;
    idx_nxt      = idx_r;

    if (out_fire) begin
      if (run_last) begin
        run_v_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + 3'd1;
      end
    end

    if (in_fire) begin
      idx_nxt      = '0;
      run_byte_nxt = in_ch.in_byte;
      unique case (in_ch.opcode)
        coct_pkg::OP_TEXT: begin
          run_v_nxt = 1'b1;
          // a held CR within the same text means the LF goes out alone
          if (in_ch.in_byte == coct_pkg::CHR_LF && !(prev_cr_r && !in_ch.text_start)) begin
            run_kind_nxt = coct_pkg::RUN_CRLF;
          end else begin
            run_kind_nxt = coct_pkg::RUN_SINGLE;
          end
          row_nxt     = row_trk[DIM_BITS-1:0];
          col_nxt     = col_trk[DIM_BITS-1:0];
          prev_cr_nxt = (in_ch.in_byte == coct_pkg::CHR_CR);
        end
        coct_pkg::OP_RAW: begin
          run_v_nxt    = 1'b1;
          run_kind_nxt = coct_pkg::RUN_SINGLE;
          prev_cr_nxt  = 1'b0;
        end
        coct_pkg::OP_CLEAR: begin
          run_v_nxt    = 1'b1;
          run_kind_nxt = coct_pkg::RUN_CLEAR;
          row_nxt      = '0;
          col_nxt      = '0;
          prev_cr_nxt  = 1'b0;
        end
        default: begin
          // undefined opcode: taken, nothing sent, state kept
          run_v_nxt = 1'b0;
        end
      endcase
    end

    // reported cursor is the low byte of the state after the item
    row_out_ext = CW'(row_nxt);
    col_out_ext = CW'(col_nxt);
    run_row_nxt = in_fire ? row_out_ext[7:0] : run_row_r;
    run_col_nxt = in_fire ? col_out_ext[7:0] : run_col_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r     <= '0;
      col_r     <= '0;
      prev_cr_r <= 1'b0;
      run_v_r   <= 1'b0;
      idx_r     <= '0;
    end else begin
      row_r     <= row_nxt;
      col_r     <= col_nxt;
      prev_cr_r <= prev_cr_nxt;
      run_v_r   <= run_v_nxt;
      idx_r     <= idx_nxt;
    end
  end

  // payload of the run, no reset needed
  always_ff @(posedge clk) begin
    run_kind_r <= run_kind_nxt;
    run_byte_r <= run_byte_nxt;
    run_row_r  <= run_row_nxt;
    run_col_r  <= run_col_nxt;
  end

  // ---------------------------------------------------------------------------
  // byte selection for the sink
  // ---------------------------------------------------------------------------
  always_comb begin
    case (run_kind_r)
      coct_pkg::RUN_CRLF: begin
        out_ch.out_byte = (idx_r == 3'd0) ? coct_pkg::CHR_CR : coct_pkg::CHR_LF;
        run_last        = (idx_r == 3'd1);
      end
      coct_pkg::RUN_CLEAR: begin
        out_ch.out_byte = coct_pkg::clear_seq_byte(idx_r);
        run_last        = (idx_r == 3'(coct_pkg::CLEAR_LEN - 1));
      end
      default: begin
        out_ch.out_byte = run_byte_r;
        run_last        = 1'b1;
      end
    endcase
  end

  assign out_ch.valid       = run_v_r;
  assign out_ch.last_of_run = run_last;
  assign out_ch.row_now     = run_row_r;
  assign out_ch.col_now     = run_col_r;

endmodule

// File: src/coct_checker.sv
`include "console_output_cursor_tracker_macros.svh"

module coct_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       last_of_run,
  input logic [7:0] row_now,
  input logic [7:0] col_now
);

  // a stalled byte holds
  `COCT_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
    out_valid && $stable(out_byte) && $stable(last_of_run), "stalled output byte changed")

  // no new item while the current run still has bytes to send
  `COCT_ASSERT_IMP(a_in_blocked, clk, rst_n, out_valid && !(out_ready && last_of_run),
    !in_ready, "input taken while a run is pending")

  // a run continues after a non-final byte goes
  `COCT_ASSERT_NXT(a_run_cont, clk, rst_n, out_valid && out_ready && !last_of_run,
    out_valid, "run ended early")

  // the cursor report is the same on every byte of a run
  `COCT_ASSERT_NXT(a_cursor_run, clk, rst_n, out_valid && out_ready && !last_of_run,
    $stable(row_now) && $stable(col_now), "cursor changed inside a run")

endmodule

bind console_output_cursor_tracker coct_checker u_coct_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_byte    (out_ch.out_byte),
  .last_of_run (out_ch.last_of_run),
  .row_now     (out_ch.row_now),
  .col_now     (out_ch.col_now)
);
